// ----- rtl/slgs_pkg.sv -----
// Shared constants, codes and controller/datapath structs for the sorted list search core.
package slgs_pkg;

	localparam int TABLE_DEPTH = 1024;
	localparam int VAL_W       = 63;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int CNT_W       = IDX_W + 1;
	localparam int TYPE_W      = 3;
	localparam int STAT_W      = 2;

	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [CNT_W-1:0] cnt_t;
	typedef logic [VAL_W-1:0] val_t;

	// request codes
	localparam logic [TYPE_W-1:0] REQ_CLEAR  = 3'd0;
	localparam logic [TYPE_W-1:0] REQ_APPEND = 3'd1;
	localparam logic [TYPE_W-1:0] REQ_FIRST  = 3'd2;
	localparam logic [TYPE_W-1:0] REQ_LAST   = 3'd3;
	localparam logic [TYPE_W-1:0] REQ_NTH    = 3'd4;
	localparam logic [TYPE_W-1:0] REQ_COUNT  = 3'd5;

	// result status codes
	localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
	localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [STAT_W-1:0] ST_FULL      = 2'd2;

	// sources for the fetch index register
	localparam logic [2:0] FS_LO    = 3'd0;
	localparam logic [2:0] FS_LO_M1 = 3'd1;
	localparam logic [2:0] FS_NTH   = 3'd2;
	localparam logic [2:0] FS_LAST  = 3'd3;
	localparam logic [2:0] FS_TOTAL = 3'd4;

	// cursor load sources
	localparam logic CUR_LO   = 1'b0;
	localparam logic CUR_FIDX = 1'b1;

	// result word kinds
	localparam logic [2:0] KIND_HIT  = 3'd0;
	localparam logic [2:0] KIND_APP  = 3'd1;
	localparam logic [2:0] KIND_OK0  = 3'd2;
	localparam logic [2:0] KIND_NF   = 3'd3;
	localparam logic [2:0] KIND_FULL = 3'd4;

	typedef struct packed {
		logic       in_ready;
		logic       clear;
		logic       append;
		logic       rd_en;
		logic       rd_fidx;
		logic       fidx_load;
		logic [2:0] fidx_src;
		logic       cur_load;
		logic       cur_src;
		logic       srch_init;
		logic       srch_hi_key;
		logic       srch_le;
		logic       srch_step;
		logic       save_first;
		logic       out_load;
		logic [2:0] out_kind;
	} slgs_cmd_t;

	typedef struct packed {
		logic              in_valid;
		logic [TYPE_W-1:0] req_type;
		logic              empty;
		logic              full;
		logic              nth_oob;
		logic              app_bad;
		logic              srch_last;
		logic              lo_at_total;
		logic              lo_zero;
		logic              lo_gt_first;
		logic              out_free;
	} slgs_stat_t;

endpackage

// ----- rtl/slgs_if.sv -----
// Request and result channel interfaces of the sorted list search core.
interface slgs_req_if import slgs_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [TYPE_W-1:0] req_type;
	val_t              query_value;
	val_t              range_high;
	idx_t              entry_index;

	modport source (output valid, output req_type, output query_value, output range_high,
		output entry_index, input ready);
	modport sink (input valid, input req_type, input query_value, input range_high,
		input entry_index, output ready);
endinterface

interface slgs_rsp_if import slgs_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [STAT_W-1:0] status;
	idx_t              hit_index;
	val_t              hit_value;
	cnt_t              match_count;

	modport source (output valid, output status, output hit_index, output hit_value,
		output match_count, input ready);
	modport sink (input valid, input status, input hit_index, input hit_value,
		input match_count, output ready);
endinterface

// ----- rtl/sorted_list_galloping_search_core.sv -----
// Sorted position table with cursor-based galloping search; one request word at a time.
// Each word is decoded; clear, full, unused code and nth past the end then load the result;
// append checks the last entry unless the table is empty, then writes; read nth fetches the
// entry; a search runs probes of the single table read port (gallop plus binary), fetching hits;
// a range count runs up to two searches. The next word is taken the cycle after the result load.
// Reset clears entry count and cursor; table contents stay undefined until appended.
module sorted_list_galloping_search_core import slgs_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	slgs_req_if.sink   req,
	slgs_rsp_if.source rsp
);

	slgs_cmd_t  cmd;
	slgs_stat_t st;

	slgs_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.st     (st),
		.cmd    (cmd)
	);

	slgs_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.cmd    (cmd),
		.st     (st)
	);

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> st.out_free)
		else $error("result register overwritten while held");

	a_append_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.append |-> !st.full)
		else $error("append into full table");

	a_one_word: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> !req.ready)
		else $error("second word taken while busy");

endmodule

// ----- rtl/slgs_dp.sv -----
// Datapath: position table, cursor, galloping/binary search unit and result register.
module slgs_dp import slgs_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	slgs_req_if.sink   req,
	slgs_rsp_if.source rsp,
	input  slgs_cmd_t  cmd,
	output slgs_stat_t st
);

	logic [TYPE_W-1:0] type_q;
	val_t              key_q;
	val_t              high_q;
	idx_t              nth_q;

	cnt_t total_q;
	idx_t cursor_q;

	val_t mem_q [TABLE_DEPTH];
	val_t rd_data_q;
	idx_t rd_addr;

	// search state
	val_t skey_q;
	logic sle_q;
	cnt_t lo_q;
	cnt_t hi_q;
	idx_t probe_q;
	cnt_t step_q;
	logic gallop_q;
	logic gfirst_q;
	logic fwd_q;
	cnt_t first_q;
	idx_t fidx_q;

	logic              out_valid_q;
	logic [STAT_W-1:0] out_status_q;
	idx_t              out_idx_q;
	val_t              out_val_q;
	cnt_t              out_cnt_q;

	logic            take;
	logic            pred;
	logic            dir_fwd;
	logic            keep;
	logic            up_ok;
	logic            dn_ok;
	logic            go_on;
	cnt_t            probe_w;
	cnt_t            lo_n;
	cnt_t            hi_n;
	cnt_t            span;
	cnt_t            mid_n;
	logic [CNT_W:0]  cand_up;
	cnt_t            cand_dn;
	cnt_t            lo_m1;
	cnt_t            total_m1;
	idx_t            fidx_d;

	assign take    = req.valid && req.ready;
	assign req.ready = cmd.in_ready;

	// one probe step: gallop outward from the cursor, then halve the bracket
	assign pred     = sle_q ? (rd_data_q <= skey_q) : (rd_data_q < skey_q);
	assign dir_fwd  = gfirst_q ? pred : fwd_q;
	assign probe_w  = {1'b0, probe_q};
	assign lo_n     = pred ? probe_w + cnt_t'(1) : lo_q;
	assign hi_n     = pred ? hi_q : probe_w;
	assign cand_up  = {1'b0, probe_w} + {1'b0, step_q};
	assign cand_dn  = probe_w - step_q;
	assign keep     = dir_fwd ? pred : !pred;
	assign up_ok    = cand_up < {1'b0, hi_n};
	assign dn_ok    = (probe_w >= step_q) && (cand_dn >= lo_n);
	assign go_on    = gallop_q && keep && (dir_fwd ? up_ok : dn_ok);
	assign span     = hi_n - lo_n;
	assign mid_n    = lo_n + (span >> 1);

	assign lo_m1    = lo_q - cnt_t'(1);
	assign total_m1 = total_q - cnt_t'(1);

	always_comb begin
		unique case (cmd.fidx_src)
			FS_LO:    fidx_d = lo_q[IDX_W-1:0];
			FS_LO_M1: fidx_d = lo_m1[IDX_W-1:0];
			FS_NTH:   fidx_d = nth_q;
			FS_LAST:  fidx_d = total_m1[IDX_W-1:0];
			FS_TOTAL: fidx_d = total_q[IDX_W-1:0];
			default:  fidx_d = lo_q[IDX_W-1:0];
		endcase
	end

	assign rd_addr = cmd.rd_fidx ? fidx_q : probe_q;

	always_ff @(posedge clk) begin
		if (cmd.append) begin
			mem_q[total_q[IDX_W-1:0]] <= key_q;
		end
		if (cmd.rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			type_q <= req.req_type;
			key_q  <= req.query_value;
			high_q <= req.range_high;
			nth_q  <= req.entry_index;
		end
		if (cmd.fidx_load) begin
			fidx_q <= fidx_d;
		end
		if (cmd.save_first) begin
			first_q <= lo_q;
		end
		if (cmd.srch_init) begin
			skey_q   <= cmd.srch_hi_key ? high_q : key_q;
			sle_q    <= cmd.srch_le;
			lo_q     <= '0;
			hi_q     <= total_q;
			probe_q  <= cmd.cur_load ? lo_q[IDX_W-1:0] : cursor_q;
			step_q   <= cnt_t'(1);
			gallop_q <= 1'b1;
			gfirst_q <= 1'b1;
		end else if (cmd.srch_step) begin
			lo_q     <= lo_n;
			hi_q     <= hi_n;
			gfirst_q <= 1'b0;
			if (gfirst_q) begin
				fwd_q <= pred;
			end
			if (go_on) begin
				probe_q <= dir_fwd ? cand_up[IDX_W-1:0] : cand_dn[IDX_W-1:0];
				step_q  <= step_q << 1;
			end else begin
				gallop_q <= 1'b0;
				probe_q  <= mid_n[IDX_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q  <= '0;
			cursor_q <= '0;
		end else begin
			if (cmd.clear) begin
				total_q  <= '0;
				cursor_q <= '0;
			end else begin
				if (cmd.append) begin
					total_q <= total_q + cnt_t'(1);
				end
				if (cmd.cur_load) begin
					cursor_q <= (cmd.cur_src == CUR_FIDX) ? fidx_q : lo_q[IDX_W-1:0];
				end
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			unique case (cmd.out_kind)
				KIND_HIT: begin
					out_status_q <= ST_OK;
					out_idx_q    <= fidx_q;
					out_val_q    <= rd_data_q;
					out_cnt_q    <= (type_q == REQ_COUNT) ? lo_q - first_q : '0;
				end
				KIND_APP: begin
					out_status_q <= ST_OK;
					out_idx_q    <= fidx_q;
					out_val_q    <= key_q;
					out_cnt_q    <= '0;
				end
				KIND_OK0: begin
					out_status_q <= ST_OK;
					out_idx_q    <= '0;
					out_val_q    <= '0;
					out_cnt_q    <= '0;
				end
				KIND_FULL: begin
					out_status_q <= ST_FULL;
					out_idx_q    <= '0;
					out_val_q    <= '0;
					out_cnt_q    <= '0;
				end
				default: begin
					out_status_q <= ST_NOT_FOUND;
					out_idx_q    <= '0;
					out_val_q    <= '0;
					out_cnt_q    <= '0;
				end
			endcase
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.status      = out_status_q;
	assign rsp.hit_index   = out_idx_q;
	assign rsp.hit_value   = out_val_q;
	assign rsp.match_count = out_cnt_q;

	assign st.in_valid    = req.valid;
	assign st.req_type    = type_q;
	assign st.empty       = (total_q == '0);
	assign st.full        = (total_q == cnt_t'(TABLE_DEPTH));
	assign st.nth_oob     = ({1'b0, nth_q} >= total_q);
	assign st.app_bad     = (rd_data_q >= key_q);
	assign st.srch_last   = !go_on && (lo_n >= hi_n);
	assign st.lo_at_total = (lo_q == total_q);
	assign st.lo_zero     = (lo_q == '0);
	assign st.lo_gt_first = (lo_q > first_q);
	assign st.out_free    = !out_valid_q || rsp.ready;

endmodule

// ----- rtl/slgs_ctrl.sv -----
// Controller state machine sequencing requests, search probes and result loading.
module slgs_ctrl import slgs_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  slgs_stat_t st,
	output slgs_cmd_t  cmd
);

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_DECODE = 4'd1;
	localparam logic [3:0] S_APP_RD = 4'd2;
	localparam logic [3:0] S_APP_EV = 4'd3;
	localparam logic [3:0] S_APP_WR = 4'd4;
	localparam logic [3:0] S_PRB_RD = 4'd5;
	localparam logic [3:0] S_PRB_EV = 4'd6;
	localparam logic [3:0] S_SDONE  = 4'd7;
	localparam logic [3:0] S_FET_RD = 4'd8;
	localparam logic [3:0] S_RESULT = 4'd9;

	logic [3:0] state_q, state_d;
	logic [2:0] kind_q, kind_d;
	logic       pass2_q, pass2_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			kind_q  <= KIND_NF;
			pass2_q <= 1'b0;
		end else begin
			state_q <= state_d;
			kind_q  <= kind_d;
			pass2_q <= pass2_d;
		end
	end

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		kind_d  = kind_q;
		pass2_d = pass2_q;
		unique case (state_q)
			S_IDLE: begin
				cmd.in_ready = 1'b1;
				pass2_d      = 1'b0;
				if (st.in_valid) begin
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				unique case (st.req_type)
					REQ_CLEAR: begin
						cmd.clear = 1'b1;
						kind_d    = KIND_OK0;
						state_d   = S_RESULT;
					end
					REQ_APPEND: begin
						priority if (st.full) begin
							kind_d  = KIND_FULL;
							state_d = S_RESULT;
						end else if (st.empty) begin
							state_d = S_APP_WR;
						end else begin
							cmd.fidx_load = 1'b1;
							cmd.fidx_src  = FS_LAST;
							state_d       = S_APP_RD;
						end
					end
					REQ_FIRST, REQ_LAST, REQ_COUNT: begin
						cmd.srch_init = 1'b1;
						cmd.srch_le   = (st.req_type == REQ_LAST);
						state_d       = st.empty ? S_SDONE : S_PRB_RD;
					end
					REQ_NTH: begin
						if (st.nth_oob) begin
							kind_d  = KIND_NF;
							state_d = S_RESULT;
						end else begin
							cmd.fidx_load = 1'b1;
							cmd.fidx_src  = FS_NTH;
							state_d       = S_FET_RD;
						end
					end
					default: begin
						kind_d  = KIND_NF;
						state_d = S_RESULT;
					end
				endcase
			end
			S_APP_RD: begin
				cmd.rd_en   = 1'b1;
				cmd.rd_fidx = 1'b1;
				state_d     = S_APP_EV;
			end
			S_APP_EV: begin
				if (st.app_bad) begin
					kind_d  = KIND_NF;
					state_d = S_RESULT;
				end else begin
					state_d = S_APP_WR;
				end
			end
			S_APP_WR: begin
				cmd.append    = 1'b1;
				cmd.fidx_load = 1'b1;
				cmd.fidx_src  = FS_TOTAL;
				kind_d        = KIND_APP;
				state_d       = S_RESULT;
			end
			S_PRB_RD: begin
				cmd.rd_en = 1'b1;
				state_d   = S_PRB_EV;
			end
			S_PRB_EV: begin
				cmd.srch_step = 1'b1;
				state_d       = st.srch_last ? S_SDONE : S_PRB_RD;
			end
			S_SDONE: begin
				priority if (st.req_type == REQ_FIRST) begin
					if (st.lo_at_total) begin
						kind_d  = KIND_NF;
						state_d = S_RESULT;
					end else begin
						cmd.fidx_load = 1'b1;
						cmd.fidx_src  = FS_LO;
						state_d       = S_FET_RD;
					end
				end else if (st.req_type == REQ_LAST) begin
					if (st.lo_zero) begin
						kind_d  = KIND_NF;
						state_d = S_RESULT;
					end else begin
						cmd.fidx_load = 1'b1;
						cmd.fidx_src  = FS_LO_M1;
						state_d       = S_FET_RD;
					end
				end else if (!pass2_q) begin
					// range count, low end located
					if (st.lo_at_total) begin
						kind_d  = KIND_OK0;
						state_d = S_RESULT;
					end else begin
						cmd.cur_load    = 1'b1;
						cmd.cur_src     = CUR_LO;
						cmd.save_first  = 1'b1;
						cmd.srch_init   = 1'b1;
						cmd.srch_hi_key = 1'b1;
						cmd.srch_le     = 1'b1;
						pass2_d         = 1'b1;
						state_d         = S_PRB_RD;
					end
				end else begin
					if (st.lo_gt_first) begin
						cmd.fidx_load = 1'b1;
						cmd.fidx_src  = FS_LO_M1;
						state_d       = S_FET_RD;
					end else begin
						kind_d  = KIND_OK0;
						state_d = S_RESULT;
					end
				end
			end
			S_FET_RD: begin
				cmd.rd_en    = 1'b1;
				cmd.rd_fidx  = 1'b1;
				cmd.cur_load = (st.req_type != REQ_NTH);
				cmd.cur_src  = CUR_FIDX;
				kind_d       = KIND_HIT;
				state_d      = S_RESULT;
			end
			S_RESULT: begin
				cmd.out_kind = kind_q;
				if (st.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

// ----- tb/sorted_list_galloping_search_core_test.sv -----
// Self-checking testbench for the sorted list galloping search core: directed table, then random.
module sorted_list_galloping_search_core_test import slgs_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [TYPE_W-1:0] REQ_SPARE6 = 3'd6;
	localparam logic [TYPE_W-1:0] REQ_SPARE7 = 3'd7;
	localparam val_t VALUE_MAX   = '1;
	localparam int   CYCLE_LIMIT = 1000000;
	localparam int   SETTLE      = 120;
	localparam int   MIX_ITEMS   = 300;

	typedef struct packed {
		logic [TYPE_W-1:0] kind;
		val_t              key;
		val_t              high;
		idx_t              nth;
	} request_t;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		idx_t              hit_index;
		val_t              hit_value;
		cnt_t              match_count;
	} result_t;

	typedef struct packed {
		request_t word;
		logic     typed;
		result_t  want;
	} row_t;

	localparam result_t MISS = '{ST_NOT_FOUND, 0, 0, 0};
	localparam result_t OK0  = '{ST_OK, 0, 0, 0};

	// known answers are typed in; the rest come from the predictor
	row_t directed_rows [0:24] = '{
		'{'{REQ_FIRST,  0,         0,         0},      1'b1, MISS},
		'{'{REQ_LAST,   VALUE_MAX, 0,         0},      1'b1, MISS},
		'{'{REQ_NTH,    0,         0,         0},      1'b1, MISS},
		'{'{REQ_COUNT,  0,         VALUE_MAX, 0},      1'b1, OK0},
		'{'{REQ_APPEND, 0,         VALUE_MAX, 10'h3ff}, 1'b1, OK0},
		'{'{REQ_APPEND, 0,         0,         0},      1'b1, MISS},
		'{'{REQ_APPEND, 5,         0,         0},      1'b1, '{ST_OK, 1, 5, 0}},
		'{'{REQ_APPEND, 1000,      0,         0},      1'b0, OK0},
		'{'{REQ_APPEND, VALUE_MAX, 0,         0},      1'b1, '{ST_OK, 3, VALUE_MAX, 0}},
		'{'{REQ_APPEND, VALUE_MAX, 0,         0},      1'b1, MISS},
		'{'{REQ_FIRST,  1,         0,         0},      1'b0, OK0},
		'{'{REQ_FIRST,  VALUE_MAX, 0,         0},      1'b0, OK0},
		'{'{REQ_LAST,   4,         0,         0},      1'b0, OK0},
		'{'{REQ_LAST,   0,         0,         0},      1'b0, OK0},
		'{'{REQ_NTH,    0,         0,         3},      1'b0, OK0},
		'{'{REQ_NTH,    0,         0,         4},      1'b1, MISS},
		'{'{REQ_NTH,    VALUE_MAX, VALUE_MAX, 10'h3ff}, 1'b1, MISS},
		'{'{REQ_COUNT,  0,         VALUE_MAX, 0},      1'b0, OK0},
		'{'{REQ_COUNT,  6,         999,       0},      1'b0, OK0},
		'{'{REQ_COUNT,  1000,      5,         0},      1'b0, OK0},
		'{'{REQ_COUNT,  VALUE_MAX, VALUE_MAX, 0},      1'b0, OK0},
		'{'{REQ_SPARE6, VALUE_MAX, VALUE_MAX, 10'h3ff}, 1'b1, MISS},
		'{'{REQ_SPARE7, 0,         0,         0},      1'b1, MISS},
		'{'{REQ_CLEAR,  VALUE_MAX, VALUE_MAX, 10'h3ff}, 1'b1, OK0},
		'{'{REQ_LAST,   VALUE_MAX, 0,         0},      1'b1, MISS}
	};

	logic clk;
	logic arst_n;

	slgs_req_if req_ch ();
	slgs_rsp_if rsp_ch ();

	sorted_list_galloping_search_core i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// predictor state
	val_t    stored_pos [TABLE_DEPTH];
	int      stored_total;
	int      cursor_pos;
	result_t pending_results [$];

	int send_idle_pct;
	int recv_idle_pct;
	int hold_left;
	int mismatch_count;
	int cycle_count;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic int count_below(val_t key);
		int lo, hi, mid;
		lo = 0;
		hi = stored_total;
		while (lo < hi) begin
			mid = lo + (hi - lo) / 2;
			if (stored_pos[mid] < key) lo = mid + 1;
			else hi = mid;
		end
		return lo;
	endfunction

	function automatic int count_not_above(val_t key);
		int lo, hi, mid;
		lo = 0;
		hi = stored_total;
		while (lo < hi) begin
			mid = lo + (hi - lo) / 2;
			if (stored_pos[mid] <= key) lo = mid + 1;
			else hi = mid;
		end
		return lo;
	endfunction

	function automatic result_t apply_request(request_t w);
		result_t res;
		int      f, c;
		res = OK0;
		case (w.kind)
			REQ_CLEAR: begin
				stored_total = 0;
				cursor_pos   = 0;
			end
			REQ_APPEND: begin
				if (stored_total >= TABLE_DEPTH) begin
					res.status = ST_FULL;
				end else if (stored_total > 0 && stored_pos[stored_total-1] >= w.key) begin
					res.status = ST_NOT_FOUND;
				end else begin
					stored_pos[stored_total] = w.key;
					res.hit_index = idx_t'(stored_total);
					res.hit_value = w.key;
					stored_total++;
				end
			end
			REQ_FIRST: begin
				f = count_below(w.key);
				if (f >= stored_total) begin
					res.status = ST_NOT_FOUND;
				end else begin
					cursor_pos    = f;
					res.hit_index = idx_t'(f);
					res.hit_value = stored_pos[f];
				end
			end
			REQ_LAST: begin
				c = count_not_above(w.key);
				if (c == 0) begin
					res.status = ST_NOT_FOUND;
				end else begin
					cursor_pos    = c - 1;
					res.hit_index = idx_t'(c - 1);
					res.hit_value = stored_pos[c-1];
				end
			end
			REQ_NTH: begin
				if (int'(w.nth) >= stored_total) begin
					res.status = ST_NOT_FOUND;
				end else begin
					res.hit_index = w.nth;
					res.hit_value = stored_pos[w.nth];
				end
			end
			REQ_COUNT: begin
				f = count_below(w.key);
				if (f < stored_total) begin
					cursor_pos = f;
					if (stored_pos[f] <= w.high) begin
						c               = count_not_above(w.high);
						cursor_pos      = c - 1;
						res.match_count = cnt_t'(c - f);
						res.hit_index   = idx_t'(c - 1);
						res.hit_value   = stored_pos[c-1];
					end
				end
			end
			default: res.status = ST_NOT_FOUND;
		endcase
		return res;
	endfunction

	function automatic val_t rand_value();
		return val_t'({$urandom, $urandom});
	endfunction

	function automatic val_t add_clamped(val_t base, logic [63:0] step);
		logic [63:0] sum;
		sum = {1'b0, base} + step;
		return (sum > {1'b0, VALUE_MAX}) ? VALUE_MAX : val_t'(sum);
	endfunction

	// search key near a stored entry most of the time
	function automatic val_t pick_key();
		val_t k;
		if (stored_total > 0 && $urandom_range(0, 99) < 70) begin
			k = stored_pos[$urandom_range(0, stored_total - 1)];
			case ($urandom_range(0, 2))
				0: if (k != 0) k = k - 1;
				2: if (k != VALUE_MAX) k = k + 1;
				default: ;
			endcase
		end else begin
			k = rand_value() >> $urandom_range(0, 62);
		end
		return k;
	endfunction

	function automatic val_t next_append_value(logic wide_gaps);
		logic [63:0] gap;
		if (stored_total == 0) return rand_value() >> $urandom_range(20, 62);
		case (wide_gaps ? $urandom_range(0, 2) : $urandom_range(0, 1))
			0:       gap = $urandom_range(0, 3);
			1:       gap = $urandom_range(0, 1000);
			default: gap = {1'b0, rand_value() >> $urandom_range(12, 62)};
		endcase
		return add_clamped(stored_pos[stored_total-1], gap + 1);
	endfunction

	// value at or below the last entry, so the append is refused; a fresh value on an empty table
	function automatic val_t stale_append_value();
		logic [63:0] last;
		if (stored_total == 0) return next_append_value(1'b1);
		last = {1'b0, stored_pos[stored_total-1]};
		if ($urandom_range(0, 1) != 0) return val_t'(last);
		return val_t'({1'b0, rand_value()} % (last + 1));
	endfunction

	function automatic request_t random_word(logic allow_clear);
		request_t w;
		int       roll;
		w.kind = REQ_FIRST;
		w.key  = rand_value();
		w.high = rand_value();
		w.nth  = idx_t'($urandom);
		roll   = $urandom_range(0, 99);
		if (allow_clear && roll < 1) begin
			w.kind = REQ_CLEAR;
		end else if (roll < 4) begin
			w.kind = ($urandom_range(0, 1) != 0) ? REQ_SPARE6 : REQ_SPARE7;
		end else if (roll < 24) begin
			w.kind = REQ_APPEND;
			w.key  = next_append_value(1'b1);
		end else if (roll < 30) begin
			w.kind = REQ_APPEND;
			w.key  = stale_append_value();
		end else if (roll < 50) begin
			w.kind = REQ_FIRST;
			w.key  = pick_key();
		end else if (roll < 65) begin
			w.kind = REQ_LAST;
			w.key  = pick_key();
		end else if (roll < 80) begin
			w.kind = REQ_NTH;
			if (stored_total > 0 && $urandom_range(0, 3) != 0)
				w.nth = idx_t'($urandom_range(0, stored_total - 1));
		end else begin
			w.kind = REQ_COUNT;
			w.key  = pick_key();
			case ($urandom_range(0, 3))
				0, 1: w.high = add_clamped(w.key, $urandom_range(0, 3000));
				2:    w.high = pick_key();
				default: ;
			endcase
		end
		return w;
	endfunction

	task automatic send_word(request_t w, logic use_typed, result_t typed_res);
		result_t predicted;
		if ($urandom_range(0, 99) < send_idle_pct) begin
			@(negedge clk);
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(0, 5)) @(negedge clk);
		end
		@(negedge clk);
		req_ch.valid       <= 1'b1;
		req_ch.req_type    <= w.kind;
		req_ch.query_value <= w.key;
		req_ch.range_high  <= w.high;
		req_ch.entry_index <= w.nth;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		predicted = apply_request(w);
		pending_results.push_back(use_typed ? typed_res : predicted);
	endtask

	task automatic pause_until_drained();
		@(negedge clk);
		req_ch.valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	// receiver: random back-pressure plus an occasional long hold-off
	initial begin
		rsp_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				rsp_ch.ready <= 1'b0;
				hold_left--;
			end else begin
				rsp_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		result_t want;
		if (rsp_ch.valid && rsp_ch.ready) begin
			if (pending_results.size() == 0) begin
				$error("result word with nothing expected: status %0d index %0d",
					rsp_ch.status, rsp_ch.hit_index);
				mismatch_count++;
			end else begin
				want = pending_results.pop_front();
				if (rsp_ch.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, rsp_ch.status);
					mismatch_count++;
				end
				if (rsp_ch.hit_index !== want.hit_index) begin
					$error("hit_index: expected %0d, got %0d", want.hit_index, rsp_ch.hit_index);
					mismatch_count++;
				end
				if (rsp_ch.hit_value !== want.hit_value) begin
					$error("hit_value: expected %0h, got %0h", want.hit_value, rsp_ch.hit_value);
					mismatch_count++;
				end
				if (rsp_ch.match_count !== want.match_count) begin
					$error("match_count: expected %0d, got %0d", want.match_count,
						rsp_ch.match_count);
					mismatch_count++;
				end
			end
		end
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("FAIL sorted_list_galloping_search_core");
		$finish;
	end

	initial begin
		request_t w;
		int       roll;
		req_ch.valid       = 1'b0;
		req_ch.req_type    = REQ_CLEAR;
		req_ch.query_value = '0;
		req_ch.range_high  = '0;
		req_ch.entry_index = '0;
		stored_total   = 0;
		cursor_pos     = 0;
		mismatch_count = 0;
		hold_left      = 0;
		send_idle_pct  = 27;
		recv_idle_pct  = 60;
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[i])
			send_word(directed_rows[i].word, directed_rows[i].typed, directed_rows[i].want);
		for (int n = 0; n < MIX_ITEMS; n++)
			send_word(random_word(1'b1), 1'b0, OK0);
		pause_until_drained();

		// swap idling; receiver stalls hard while words keep coming
		send_idle_pct = 60;
		recv_idle_pct = 27;
		hold_left     = 400;
		for (int n = 0; n < MIX_ITEMS; n++)
			send_word(random_word(1'b1), 1'b0, OK0);

		// no idling: fill the table to the brim with some noise mixed in
		send_idle_pct = 0;
		recv_idle_pct = 0;
		w      = random_word(1'b0);
		w.kind = REQ_CLEAR;
		send_word(w, 1'b0, OK0);
		while (stored_total < TABLE_DEPTH) begin
			roll = $urandom_range(0, 99);
			w    = random_word(1'b0);
			if (roll >= 8) begin
				w.kind = REQ_APPEND;
				w.key  = (roll < 12) ? stale_append_value() : next_append_value(1'b0);
			end
			send_word(w, 1'b0, OK0);
		end
		repeat (3) begin
			w      = random_word(1'b0);
			w.kind = REQ_APPEND;
			w.key  = add_clamped(stored_pos[TABLE_DEPTH-1], $urandom_range(1, 100));
			send_word(w, 1'b0, OK0);
		end
		w      = random_word(1'b0);
		w.kind = REQ_COUNT;
		w.key  = '0;
		w.high = VALUE_MAX;
		send_word(w, 1'b0, OK0);
		w.kind = REQ_NTH;
		w.nth  = '1;
		send_word(w, 1'b0, OK0);
		for (int n = 0; n < 100; n++)
			send_word(random_word(1'b0), 1'b0, OK0);

		pause_until_drained();
		repeat (SETTLE) @(posedge clk);
		if (mismatch_count == 0 && pending_results.size() == 0) begin
			$display("PASS sorted_list_galloping_search_core");
		end else begin
			$display("FAIL sorted_list_galloping_search_core");
		end
		$finish;
	end

endmodule
